@@ hdl/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and helpers for the quaternion vertex rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int QUAT_WIDTH     = 16;

	// q * v : one product, three terms plus rounding constant
	localparam int PROD1_W = QUAT_WIDTH + COORD_WIDTH;
	localparam int SUM1_W  = (PROD1_W + 2 > QUAT_FRAC_BITS + 2) ?
		PROD1_W + 2 : QUAT_FRAC_BITS + 2;
	localparam int PV_W    = SUM1_W - QUAT_FRAC_BITS;

	// (q * v) * conj(q) : four terms plus rounding constant
	localparam int PROD2_W = PV_W + QUAT_WIDTH;
	localparam int SUM2_W  = (PROD2_W + 3 > QUAT_FRAC_BITS + 2) ?
		PROD2_W + 3 : QUAT_FRAC_BITS + 2;
	localparam int RES_W   = (SUM2_W - QUAT_FRAC_BITS > COORD_WIDTH) ?
		SUM2_W - QUAT_FRAC_BITS : COORD_WIDTH + 1;

	localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

	localparam logic [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'd16384;

	typedef struct packed {
		logic [QUAT_WIDTH-1:0] w;
		logic [QUAT_WIDTH-1:0] x;
		logic [QUAT_WIDTH-1:0] y;
		logic [QUAT_WIDTH-1:0] z;
	} quat_t;

	typedef struct packed {
		logic [PV_W-1:0] w;
		logic [PV_W-1:0] x;
		logic [PV_W-1:0] y;
		logic [PV_W-1:0] z;
	} pv_t;

	typedef struct packed {
		logic [RES_W-1:0] x;
		logic [RES_W-1:0] y;
		logic [RES_W-1:0] z;
	} res_t;

	typedef struct packed {
		logic                   clip;
		logic [COORD_WIDTH-1:0] val;
	} sat_t;

	function automatic logic signed [PROD1_W-1:0] mul_qv(
		input logic signed [QUAT_WIDTH-1:0]  q,
		input logic signed [COORD_WIDTH-1:0] v
	);
		return q * v;
	endfunction

	function automatic logic signed [PROD2_W-1:0] mul_pq(
		input logic signed [PV_W-1:0]       p,
		input logic signed [QUAT_WIDTH-1:0] q
	);
		return p * q;
	endfunction

	function automatic sat_t sat_coord(input logic signed [RES_W-1:0] v);
		logic [RES_W-COORD_WIDTH:0] hi;
		sat_t r;
		hi = v[RES_W-1:COORD_WIDTH-1];
		if (&hi || ~|hi) begin
			r.clip = 1'b0;
			r.val  = v[COORD_WIDTH-1:0];
		end else begin
			r.clip = 1'b1;
			r.val  = v[RES_W-1] ? COORD_MIN : COORD_MAX;
		end
		return r;
	endfunction

endpackage

@@ hdl/qvr_if.sv @@
// ----------------------------------------------------------------------------
// qvr_if
// Valid/ready channels for vertices in and rotated vertices out.
// ----------------------------------------------------------------------------
interface vert_if import qvr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] vert_x;
	logic [COORD_WIDTH-1:0] vert_y;
	logic [COORD_WIDTH-1:0] vert_z;

	modport source (output valid, vert_x, vert_y, vert_z, input ready);
	modport sink   (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface rot_if import qvr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] rot_x;
	logic [COORD_WIDTH-1:0] rot_y;
	logic [COORD_WIDTH-1:0] rot_z;
	logic                   clipped;

	modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
	modport sink   (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

@@ hdl/qvr_qv_mul.sv @@
// ----------------------------------------------------------------------------
// qvr_qv_mul
// Stages 1-2: products of q and (0, v), then summed and rounded to q*v.
// ----------------------------------------------------------------------------
module qvr_qv_mul import qvr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  quat_t  quat,
	vert_if.sink   vert,
	output logic   out_valid,
	input  logic   out_ready,
	output pv_t    pv
);

	localparam logic signed [SUM1_W-1:0] RND =
		{{(SUM1_W-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

	logic en_s1, en_s2;
	logic vld_s1, vld_s2;
	logic signed [PROD1_W-1:0] prod_s1 [12];
	pv_t pv_s2;
	logic signed [SUM1_W-1:0] sum_w, sum_x, sum_y, sum_z;

	assign en_s2      = !vld_s2 || out_ready;
	assign en_s1      = !vld_s1 || en_s2;
	assign vert.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1)
				vld_s1 <= vert.valid;
			if (en_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && vert.valid) begin
			prod_s1[0]  <= mul_qv(quat.x, vert.vert_x);
			prod_s1[1]  <= mul_qv(quat.y, vert.vert_y);
			prod_s1[2]  <= mul_qv(quat.z, vert.vert_z);
			prod_s1[3]  <= mul_qv(quat.w, vert.vert_x);
			prod_s1[4]  <= mul_qv(quat.y, vert.vert_z);
			prod_s1[5]  <= mul_qv(quat.z, vert.vert_y);
			prod_s1[6]  <= mul_qv(quat.w, vert.vert_y);
			prod_s1[7]  <= mul_qv(quat.x, vert.vert_z);
			prod_s1[8]  <= mul_qv(quat.z, vert.vert_x);
			prod_s1[9]  <= mul_qv(quat.w, vert.vert_z);
			prod_s1[10] <= mul_qv(quat.x, vert.vert_y);
			prod_s1[11] <= mul_qv(quat.y, vert.vert_x);
		end
	end

	always_comb begin
		sum_w = RND - SUM1_W'(prod_s1[0]) - SUM1_W'(prod_s1[1]) - SUM1_W'(prod_s1[2]);
		sum_x = RND + SUM1_W'(prod_s1[3]) + SUM1_W'(prod_s1[4]) - SUM1_W'(prod_s1[5]);
		sum_y = RND + SUM1_W'(prod_s1[6]) - SUM1_W'(prod_s1[7]) + SUM1_W'(prod_s1[8]);
		sum_z = RND + SUM1_W'(prod_s1[9]) + SUM1_W'(prod_s1[10]) - SUM1_W'(prod_s1[11]);
	end

	// dropping the low bits is the floor shift after the half-LSB add
	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			pv_s2.w <= sum_w[SUM1_W-1:QUAT_FRAC_BITS];
			pv_s2.x <= sum_x[SUM1_W-1:QUAT_FRAC_BITS];
			pv_s2.y <= sum_y[SUM1_W-1:QUAT_FRAC_BITS];
			pv_s2.z <= sum_z[SUM1_W-1:QUAT_FRAC_BITS];
		end
	end

	assign out_valid = vld_s2;
	assign pv        = pv_s2;

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !out_ready |=> vld_s2 && $stable(pv_s2))
		else $error("q*v stage lost or changed a stalled request");

endmodule

@@ hdl/qvr_vqc_mul.sv @@
// ----------------------------------------------------------------------------
// qvr_vqc_mul
// Stages 3-4: (q*v) times conj(q), vector part summed and rounded.
// ----------------------------------------------------------------------------
module qvr_vqc_mul import qvr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  quat_t  quat,
	input  logic   in_valid,
	output logic   in_ready,
	input  pv_t    pv,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   res
);

	localparam logic signed [SUM2_W-1:0] RND =
		{{(SUM2_W-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

	logic en_s3, en_s4;
	logic vld_s3, vld_s4;
	logic signed [PROD2_W-1:0] prod_s3 [12];
	res_t res_s4;
	logic signed [SUM2_W-1:0] sum_x, sum_y, sum_z;

	assign en_s4    = !vld_s4 || out_ready;
	assign en_s3    = !vld_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s3)
				vld_s3 <= in_valid;
			if (en_s4)
				vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			prod_s3[0]  <= mul_pq(pv.w, quat.x);
			prod_s3[1]  <= mul_pq(pv.x, quat.w);
			prod_s3[2]  <= mul_pq(pv.y, quat.z);
			prod_s3[3]  <= mul_pq(pv.z, quat.y);
			prod_s3[4]  <= mul_pq(pv.w, quat.y);
			prod_s3[5]  <= mul_pq(pv.x, quat.z);
			prod_s3[6]  <= mul_pq(pv.y, quat.w);
			prod_s3[7]  <= mul_pq(pv.z, quat.x);
			prod_s3[8]  <= mul_pq(pv.w, quat.z);
			prod_s3[9]  <= mul_pq(pv.x, quat.y);
			prod_s3[10] <= mul_pq(pv.y, quat.x);
			prod_s3[11] <= mul_pq(pv.z, quat.w);
		end
	end

	always_comb begin
		sum_x = RND - SUM2_W'(prod_s3[0]) + SUM2_W'(prod_s3[1])
			- SUM2_W'(prod_s3[2]) + SUM2_W'(prod_s3[3]);
		sum_y = RND - SUM2_W'(prod_s3[4]) + SUM2_W'(prod_s3[5])
			+ SUM2_W'(prod_s3[6]) - SUM2_W'(prod_s3[7]);
		sum_z = RND - SUM2_W'(prod_s3[8]) - SUM2_W'(prod_s3[9])
			+ SUM2_W'(prod_s3[10]) + SUM2_W'(prod_s3[11]);
	end

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			res_s4.x <= RES_W'(sum_x[SUM2_W-1:QUAT_FRAC_BITS]);
			res_s4.y <= RES_W'(sum_y[SUM2_W-1:QUAT_FRAC_BITS]);
			res_s4.z <= RES_W'(sum_z[SUM2_W-1:QUAT_FRAC_BITS]);
		end
	end

	assign out_valid = vld_s4;
	assign res       = res_s4;

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !out_ready |=> vld_s4 && $stable(res_s4))
		else $error("conj stage lost or changed a stalled request");

	a_s3_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s3)
		else $error("accepted request missing from stage 3");

endmodule

@@ hdl/qvr_sat_out.sv @@
// ----------------------------------------------------------------------------
// qvr_sat_out
// Stage 5: saturate to coordinate range, flag clipping, output register.
// ----------------------------------------------------------------------------
module qvr_sat_out import qvr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  res_t   res,
	rot_if.source  rot
);

	logic en_s5;
	logic vld_s5;
	sat_t sx, sy, sz;
	logic [COORD_WIDTH-1:0] x_s5, y_s5, z_s5;
	logic clip_s5;

	assign en_s5    = !vld_s5 || rot.ready;
	assign in_ready = en_s5;

	always_comb begin
		sx = sat_coord(res.x);
		sy = sat_coord(res.y);
		sz = sat_coord(res.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en_s5)
			vld_s5 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			x_s5    <= sx.val;
			y_s5    <= sy.val;
			z_s5    <= sz.val;
			clip_s5 <= sx.clip | sy.clip | sz.clip;
		end
	end

	assign rot.valid   = vld_s5;
	assign rot.rot_x   = x_s5;
	assign rot.rot_y   = y_s5;
	assign rot.rot_z   = z_s5;
	assign rot.clipped = clip_s5;

	// a clipped vertex has at least one coordinate pinned at a range limit
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && clip_s5 |->
			(x_s5 == COORD_MAX || x_s5 == COORD_MIN ||
			 y_s5 == COORD_MAX || y_s5 == COORD_MIN ||
			 z_s5 == COORD_MAX || z_s5 == COORD_MIN))
		else $error("clipped flag set with no coordinate at a limit");

endmodule

@@ hdl/quaternion_vector_rotate_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a vertex stream by the configured quaternion: vector part of
// q * v * conj(q), Q2.14 quaternion, rounded per product stage, saturated.
//
//   channel  dir  handshake            payload
//   vert     in   valid/ready          vert_x, vert_y, vert_z
//   rot      out  valid/ready          rot_x, rot_y, rot_z, clipped
//   cfg      in   cfg_wr_en            cfg_index, cfg_wdata
//
// One vertex per clock while rot is not stalled; two multiply/sum stages per
// product, then one saturation stage feeding the output register.
// Reset clears all stage valids and loads the identity quaternion.
// Ready ripples back stage by stage, so empty stages still take requests
// while a result waits at the output; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top import qvr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [QUAT_WIDTH-1:0] cfg_wdata,
	vert_if.sink                  vert,
	rot_if.source                 rot
);

	quat_t quat_q;
	logic  pv_valid, pv_ready;
	pv_t   pv;
	logic  res_valid, res_ready;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.w <= QUAT_W_RESET;
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUAT_W: quat_q.w <= cfg_wdata;
				REG_QUAT_X: quat_q.x <= cfg_wdata;
				REG_QUAT_Y: quat_q.y <= cfg_wdata;
				REG_QUAT_Z: quat_q.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	qvr_qv_mul u_qv_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat_q),
		.vert      (vert),
		.out_valid (pv_valid),
		.out_ready (pv_ready),
		.pv        (pv)
	);

	qvr_vqc_mul u_vqc_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat_q),
		.in_valid  (pv_valid),
		.in_ready  (pv_ready),
		.pv        (pv),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.res       (res)
	);

	qvr_sat_out u_sat_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.res      (res),
		.rot      (rot)
	);

	a_cfg_w: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && cfg_index == REG_QUAT_W |=> quat_q.w == $past(cfg_wdata))
		else $error("quat_w register did not take the write");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr_en |=> $stable(quat_q))
		else $error("quaternion changed without a write");

endmodule

@@ tb/tb_quaternion_vector_rotate_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_top
// Self-checking bench for the vertex rotator. Streams vertices under a series
// of quaternion settings and handshake idle patterns, predicts the rotated
// vertex with the same per-stage rounding and saturation, and compares every
// result in order.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_top;
	import qvr_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] z;
	} vertex_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] z;
		logic                   clipped;
	} rotated_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [QUAT_WIDTH-1:0] cfg_wdata;

	vert_if vert ();
	rot_if  rot ();

	quaternion_vector_rotate_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.vert      (vert),
		.rot       (rot)
	);

	// local copy of the quaternion registers, indexed by register index
	logic [QUAT_WIDTH-1:0] quat_regs [4];

	vertex_t  pending_verts [$];
	rotated_t expected_rot [$];
	vertex_t  drv_vert;
	rotated_t got_rot;
	rotated_t want_rot;

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_req;
	logic hold_used;
	int hold_cnt;

	int pushed_total    = 0;
	int accepted_total  = 0;
	int result_cnt      = 0;
	int clip_cnt        = 0;
	int in_stall_cycles = 0;
	int errors          = 0;
	int cycle_cnt       = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// add half an LSB, then floor shift: halves round toward +inf
	function automatic longint round_frac(input longint s);
		return (s + (longint'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] clamp_coord(input longint v, inout logic clip);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi;
			clip = 1'b1;
		end else if (v < lo) begin
			v = lo;
			clip = 1'b1;
		end
		return v[COORD_WIDTH-1:0];
	endfunction

	// vector part of q * (0, v) * conj(q)
	function automatic rotated_t rotate_vertex(input vertex_t v);
		longint qw, qx, qy, qz;
		longint vx, vy, vz;
		longint pw, px, py, pz;
		logic clip;
		rotated_t r;
		qw = $signed(quat_regs[REG_QUAT_W]);
		qx = $signed(quat_regs[REG_QUAT_X]);
		qy = $signed(quat_regs[REG_QUAT_Y]);
		qz = $signed(quat_regs[REG_QUAT_Z]);
		vx = $signed(v.x);
		vy = $signed(v.y);
		vz = $signed(v.z);
		pw = round_frac(-(qx * vx) - (qy * vy) - (qz * vz));
		px = round_frac((qw * vx) + (qy * vz) - (qz * vy));
		py = round_frac((qw * vy) - (qx * vz) + (qz * vx));
		pz = round_frac((qw * vz) + (qx * vy) - (qy * vx));
		clip = 1'b0;
		r.x = clamp_coord(round_frac(-(pw * qx) + (px * qw) - (py * qz) + (pz * qy)), clip);
		r.y = clamp_coord(round_frac(-(pw * qy) + (px * qz) + (py * qw) - (pz * qx)), clip);
		r.z = clamp_coord(round_frac(-(pw * qz) - (px * qy) + (py * qx) + (pz * qw)), clip);
		r.clipped = clip;
		return r;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] rand_coord();
		logic [COORD_WIDTH-1:0] r;
		case ($urandom_range(0, 7))
			0: r = COORD_MAX;
			1: r = COORD_MIN;
			2: begin
				r = COORD_WIDTH'($urandom_range(0, 64));
				r = r - COORD_WIDTH'(32);
			end
			3: begin
				r = COORD_WIDTH'($urandom_range(0, 1 << 16));
				r = r - COORD_WIDTH'(1 << 15);
			end
			default: r = COORD_WIDTH'($urandom());
		endcase
		return r;
	endfunction

	task automatic compare_field(input string field, input logic signed [63:0] want_v,
		input logic signed [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
			errors++;
		end
	endtask

	task automatic push_vert(input logic [COORD_WIDTH-1:0] x, y, z);
		pending_verts.push_back('{x, y, z});
		pushed_total++;
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++) begin
			push_vert(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [QUAT_WIDTH-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		quat_regs[idx] = val;
	endtask

	task automatic write_quat(input logic [QUAT_WIDTH-1:0] qw, qx, qy, qz);
		cfg_write(REG_QUAT_W, qw);
		cfg_write(REG_QUAT_X, qx);
		cfg_write(REG_QUAT_Y, qy);
		cfg_write(REG_QUAT_Z, qz);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct  <= send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// block is idle once every pushed vertex was taken and every result came back
	task automatic drain();
		do @(posedge clk);
		while (accepted_total != pushed_total || expected_rot.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// vertex driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert.valid  <= 1'b0;
			vert.vert_x <= '0;
			vert.vert_y <= '0;
			vert.vert_z <= '0;
		end else begin
			if (vert.valid && vert.ready) begin
				expected_rot.push_back(rotate_vertex({vert.vert_x, vert.vert_y, vert.vert_z}));
				accepted_total++;
			end
			if (vert.valid && !vert.ready)
				in_stall_cycles++;
			if (!vert.valid || vert.ready) begin
				if (pending_verts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_vert = pending_verts.pop_front();
					vert.valid  <= 1'b1;
					vert.vert_x <= drv_vert.x;
					vert.vert_y <= drv_vert.y;
					vert.vert_z <= drv_vert.z;
				end else begin
					vert.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot.ready <= 1'b0;
		end else begin
			if (rot.valid && rot.ready) begin
				got_rot = {rot.rot_x, rot.rot_y, rot.rot_z, rot.clipped};
				result_cnt++;
				if (got_rot.clipped === 1'b1)
					clip_cnt++;
				if (expected_rot.size() == 0) begin
					$display("%0t: unexpected request on rot: (%0d, %0d, %0d) clipped %0b",
						$time, $signed(got_rot.x), $signed(got_rot.y), $signed(got_rot.z),
						got_rot.clipped);
					errors++;
				end else begin
					want_rot = expected_rot.pop_front();
					compare_field("rot_x", $signed(want_rot.x), $signed(got_rot.x));
					compare_field("rot_y", $signed(want_rot.y), $signed(got_rot.y));
					compare_field("rot_z", $signed(want_rot.z), $signed(got_rot.z));
					compare_field("clipped", want_rot.clipped, got_rot.clipped);
				end
			end
			rot.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// one long output hold-off so the pipeline fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_used <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d requests still pending", $time, expected_rot.size());
			$display("quaternion_vector_rotate_top: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = REG_QUAT_W;
		cfg_wdata   = '0;
		vert.valid  = 1'b0;
		vert.vert_x = '0;
		vert.vert_y = '0;
		vert.vert_z = '0;
		rot.ready   = 1'b0;
		hold_req    = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quat_regs[REG_QUAT_W] = QUAT_W_RESET;
		quat_regs[REG_QUAT_X] = '0;
		quat_regs[REG_QUAT_Y] = '0;
		quat_regs[REG_QUAT_Z] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// identity after reset: field extremes pass straight through
		set_idling(0, 0);
		push_vert(0, 0, 0);
		push_vert(COORD_MAX, COORD_MAX, COORD_MAX);
		push_vert(COORD_MIN, COORD_MIN, COORD_MIN);
		push_vert(COORD_MAX, COORD_MIN, 0);
		push_vert(-1, 1, -1);
		push_vert(COORD_MIN, COORD_MAX, COORD_MIN);
		push_vert(24'h555555, 24'haaaaaa, 24'h0f0f0f);
		push_vert(24'haaaaaa, 24'h555555, 24'hf0f0f0);
		push_random(60);
		drain();

		// half scale: exact halves in both rounding stages
		write_quat(16'sd8192, 0, 0, 0);
		set_idling(81, 0);
		push_vert(1, -1, 3);
		push_vert(-3, 5, -5);
		push_vert(2, -2, 6);
		push_vert(COORD_MAX, COORD_MIN, 1);
		push_vert(7, -7, -9);
		push_vert(COORD_MIN, COORD_MAX, -1);
		push_random(60);
		drain();

		// largest positive non-unit quaternion: heavy saturation
		write_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		set_idling(0, 81);
		push_vert(COORD_MAX, COORD_MAX, COORD_MAX);
		push_vert(COORD_MIN, COORD_MIN, COORD_MIN);
		push_vert(COORD_MAX, COORD_MIN, COORD_MAX);
		push_random(50);
		drain();

		write_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		set_idling(29, 29);
		push_vert(COORD_MIN, COORD_MIN, COORD_MIN);
		push_vert(COORD_MAX, 0, COORD_MIN);
		push_vert(1, 1, 1);
		push_random(50);
		drain();

		// 90 degrees about z, output blocked for a long stretch
		write_quat(16'sd11585, 0, 0, 16'sd11585);
		set_idling(0, 0);
		@(posedge clk);
		hold_req <= 1'b1;
		push_random(90);
		drain();

		write_quat(0, 0, 0, 0);
		set_idling(29, 29);
		push_random(30);
		drain();

		write_quat(QUAT_WIDTH'($urandom()), QUAT_WIDTH'($urandom()),
			QUAT_WIDTH'($urandom()), QUAT_WIDTH'($urandom()));
		set_idling(81, 0);
		push_random(60);
		drain();

		// 120 degrees about a diagonal
		write_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
		set_idling(0, 81);
		push_random(60);
		drain();

		write_quat(QUAT_WIDTH'($urandom()), QUAT_WIDTH'($urandom()),
			QUAT_WIDTH'($urandom()), QUAT_WIDTH'($urandom()));
		set_idling(29, 29);
		push_random(60);
		drain();

		if (expected_rot.size() != 0) begin
			$display("%0t: %0d rotated vertices never arrived", $time, expected_rot.size());
			errors++;
		end
		$display("Rotated %0d vertices under nine quaternion settings, %0d of them clipped.",
			result_cnt, clip_cnt);
		$display("Input was back-pressured for %0d cycles; %0d errors.", in_stall_cycles, errors);
		if (errors == 0)
			$display("quaternion_vector_rotate_top: match");
		else
			$display("quaternion_vector_rotate_top: mismatch");
		$finish;
	end

endmodule
